FILE: design/npscan_pkg.sv
package npscan_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_W    = 32;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ABS_W      = COORD_W;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int ENTRY_W    = 2 * COORD_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // one stored point as it leaves the store
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] idx;
    logic [ENTRY_W-1:0] entry;
  } point_req_t;

  // one squared distance ready for the compare
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] idx;
    logic [DIST_W-1:0] dist_sq;
  } dist_res_t;

endpackage

FILE: design/npscan_ram.sv
module npscan_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/npscan_dist.sv
module npscan_dist (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [npscan_pkg::COORD_W-1:0] q_lon,
  input  logic signed [npscan_pkg::COORD_W-1:0] q_lat,
  input  npscan_pkg::point_req_t              pt,
  output npscan_pkg::dist_res_t               res,
  output logic                                busy
);

  localparam int CW = npscan_pkg::COORD_W;
  localparam int AW = npscan_pkg::ADDR_W;

  logic signed [CW-1:0] p_lon;
  logic signed [CW-1:0] p_lat;
  logic signed [CW:0]   d_lon;
  logic signed [CW:0]   d_lat;
  logic [CW:0]          n_lon;
  logic [CW:0]          n_lat;

  logic                            s1_v_r;
  logic [AW-1:0]                   s1_idx_r;
  logic [npscan_pkg::ABS_W-1:0]    s1_dx_r;
  logic [npscan_pkg::ABS_W-1:0]    s1_dy_r;
  logic                            s2_v_r;
  logic [AW-1:0]                   s2_idx_r;
  logic [npscan_pkg::SQ_W-1:0]     s2_sx_r;
  logic [npscan_pkg::SQ_W-1:0]     s2_sy_r;
  logic                            s3_v_r;
  logic [AW-1:0]                   s3_idx_r;
  logic [npscan_pkg::DIST_W-1:0]   s3_sum_r;

  assign p_lon = pt.entry[CW-1:0];
  assign p_lat = pt.entry[2*CW-1:CW];
  assign d_lon = {p_lon[CW-1], p_lon} - {q_lon[CW-1], q_lon};
  assign d_lat = {p_lat[CW-1], p_lat} - {q_lat[CW-1], q_lat};
  assign n_lon = -d_lon;
  assign n_lat = -d_lat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= pt.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
    // magnitude of a difference always fits the coordinate width unsigned
    s1_dx_r  <= d_lon[CW] ? n_lon[CW-1:0] : d_lon[CW-1:0];
    s1_dy_r  <= d_lat[CW] ? n_lat[CW-1:0] : d_lat[CW-1:0];
    s1_idx_r <= pt.idx;
    s2_sx_r  <= s1_dx_r * s1_dx_r;
    s2_sy_r  <= s1_dy_r * s1_dy_r;
    s2_idx_r <= s1_idx_r;
    s3_sum_r <= {1'b0, s2_sx_r} + {1'b0, s2_sy_r};
    s3_idx_r <= s2_idx_r;
  end

  assign res.valid   = s3_v_r;
  assign res.idx     = s3_idx_r;
  assign res.dist_sq = s3_sum_r;
  assign busy        = s1_v_r | s2_v_r | s3_v_r;

endmodule

FILE: design/nearest_point_scan_unit.sv
// Nearest point scan over a store of 2-D points.
// Input channel in_*: in_tuser is the opcode. A write request (opcode 0)
// stores lon/lat at slot and gives no result. A query
// request (opcode 1) scans entries 0 .. point_count-1 and returns the index
// of the nearest one, first index winning ties, with found clear when
// point_count is 0.
// cfg_we/cfg_wdata set point_count (values above the store size act as the
// full store); write it only while no query is in flight.
// During a query the store read port delivers one entry per cycle to a
// single distance unit (difference, square, sum) and one compare against
// the running minimum. in_tready stays low for the whole scan.
// The result sits in an output register; a write request, or a new query,
// is taken while it waits, and a query that finishes while out_tready is
// low holds until the older result is taken.
// Reset (rst_n low, synchronous) clears point_count, the state and the valid flags;
// the store keeps its contents and every scanned entry must be written first.
module nearest_point_scan_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,     // point_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,      // slot[9:0], lon[41:10], lat[73:42], zero pad
  input  logic [0:0]  in_tuser,      // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata      // closest_index[9:0], found[10], zero pad
);

  localparam int CW = npscan_pkg::COORD_W;
  localparam int AW = npscan_pkg::ADDR_W;
  localparam int NW = npscan_pkg::CNT_W;
  localparam logic [NW-1:0] MAX_CNT = NW'(npscan_pkg::MAX_POINTS);

  npscan_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]         point_count_r;
  logic [NW-1:0]         n_r, n_nxt;
  logic [NW-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic                  rd_v_r, rd_v_nxt;
  logic [AW-1:0]         rd_idx_r;
  logic signed [CW-1:0]  q_lon_r, q_lat_r;
  logic                  have_r, have_nxt;
  logic [npscan_pkg::DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic [AW-1:0]         best_idx_r, best_idx_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [AW-1:0]         out_idx_r, out_idx_nxt;
  logic                  out_found_r, out_found_nxt;

  logic                  in_acc;
  logic                  wr_en;
  logic [NW-1:0]         n_sat;
  logic [AW-1:0]         in_slot;
  logic [CW-1:0]         in_lon, in_lat;
  logic [npscan_pkg::ENTRY_W-1:0] rd_data;
  logic                  dist_busy;
  logic                  pipe_busy;
  logic                  out_free;
  npscan_pkg::point_req_t pt;
  npscan_pkg::dist_res_t  res;

  assign in_slot = in_tdata[AW-1:0];
  assign in_lon  = in_tdata[AW+CW-1:AW];
  assign in_lat  = in_tdata[AW+2*CW-1:AW+CW];
  assign in_tready = (state_r == npscan_pkg::ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign wr_en     = in_acc & (in_tuser[0] == npscan_pkg::OP_WRITE) &
                     ({1'b0, in_slot} < MAX_CNT);
  assign n_sat     = (point_count_r > MAX_CNT) ? MAX_CNT : point_count_r;
  assign pipe_busy = rd_v_r | dist_busy;
  assign out_free  = ~out_tvalid_r | out_tready;

  npscan_ram #(
    .WIDTH (npscan_pkg::ENTRY_W),
    .DEPTH (npscan_pkg::MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_slot),
    .wdata ({in_lat, in_lon}),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (rd_data)
  );

  assign pt.valid = rd_v_r;
  assign pt.idx   = rd_idx_r;
  assign pt.entry = rd_data;

  npscan_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .q_lon (q_lon_r),
    .q_lat (q_lat_r),
    .pt    (pt),
    .res   (res),
    .busy  (dist_busy)
  );

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    rd_cnt_nxt     = rd_cnt_r;
    rd_v_nxt       = 1'b0;
    have_nxt       = have_r;
    best_dist_nxt  = best_dist_r;
    best_idx_nxt   = best_idx_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_idx_nxt    = out_idx_r;
    out_found_nxt  = out_found_r;

    // strictly nearer replaces, so the earliest index keeps a tie
    if (res.valid && (!have_r || res.dist_sq < best_dist_r)) begin
      have_nxt      = 1'b1;
      best_dist_nxt = res.dist_sq;
      best_idx_nxt  = res.idx;
    end

    unique case (state_r)
      npscan_pkg::ST_IDLE: begin
        if (in_acc && in_tuser[0] == npscan_pkg::OP_QUERY) begin
          n_nxt      = n_sat;
          rd_cnt_nxt = '0;
          have_nxt   = 1'b0;
          state_nxt  = (n_sat == '0) ? npscan_pkg::ST_FINISH : npscan_pkg::ST_SCAN;
        end
      end
      npscan_pkg::ST_SCAN: begin
        rd_v_nxt   = 1'b1;
        rd_cnt_nxt = rd_cnt_r + 1'b1;
        if (rd_cnt_r == n_r - 1'b1) begin
          state_nxt = npscan_pkg::ST_DRAIN;
        end
      end
      npscan_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = npscan_pkg::ST_FINISH;
        end
      end
      npscan_pkg::ST_FINISH: begin
        // hold until the previous result has been taken
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = have_r;
          out_idx_nxt    = have_r ? best_idx_r : '0;
          state_nxt      = npscan_pkg::ST_IDLE;
        end
      end
      default: state_nxt = npscan_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npscan_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
      rd_v_r        <= 1'b0;
      have_r        <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        point_count_r <= cfg_wdata;
      end
      rd_v_r       <= rd_v_nxt;
      have_r       <= have_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    n_r         <= n_nxt;
    rd_cnt_r    <= rd_cnt_nxt;
    rd_idx_r    <= rd_cnt_r[AW-1:0];
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    out_idx_r   <= out_idx_nxt;
    out_found_r <= out_found_nxt;
    if (in_acc) begin
      q_lon_r <= in_lon;
      q_lat_r <= in_lat;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(16 - AW - 1){1'b0}}, out_found_r, out_idx_r};

`ifndef SYNTHESIS
  a_accept_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !pipe_busy)
    else $error("request accepted while the scan pipeline is busy");

  a_res_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> ({1'b0, res.idx} < n_r))
    else $error("distance result beyond the scanned range");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == npscan_pkg::ST_FINISH) && out_free |=> out_tvalid_r)
    else $error("finished query did not present a result");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_found_r |-> (out_idx_r == '0))
    else $error("empty scan returned a nonzero index");

  a_no_read_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_nxt |-> (state_r == npscan_pkg::ST_SCAN) && ({1'b0, rd_cnt_r[AW-1:0]} < n_r))
    else $error("store read outside the scan window");
`endif

endmodule
